// ===== design/assert_macros.svh =====
// Assertion macros for the checker file.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-edge implication, sampled on the rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-edge implication, sampled on the rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/u2u8_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package u2u8_pkg;

    localparam int COUNT_W = 16;
    localparam int CAP_W   = 16;
    localparam int LEN_W   = 17;
    localparam int CP_W    = 32;
    // Wide enough for both the grown byte count and the capacity.
    localparam int CMP_W   = ((COUNT_W + 1) > CAP_W) ? (COUNT_W + 2) : (CAP_W + 1);
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

    typedef enum logic [1:0] {
        ST_CHAR    = 2'd0,
        ST_END     = 2'd1,
        ST_TRUNC   = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic {
        CMD_CHAR   = 1'b0,
        CMD_SINGLE = 1'b1
    } kind_t;

    // One request handed from the front end to the byte emitter.
    typedef struct packed {
        kind_t             kind;
        logic [CP_W-2:0]   cp;
        logic [2:0]        nbytes;
        logic              bvalid;
        status_t           status;
        logic [LEN_W-1:0]  len;
    } cmd_t;

    // Byte idx (0 = lead) of the n-byte encoding of cp.
    function automatic logic [7:0] utf8_byte(input logic [CP_W-2:0] cp,
                                             input logic [2:0] n,
                                             input logic [2:0] idx);
        logic [2:0]      r;
        logic [CP_W-2:0] sh;
        logic [7:0]      lead;
        logic [7:0]      res;
        r = n - 3'd1 - idx;
        case (r)
            3'd0:    sh = cp;
            3'd1:    sh = cp >> 6;
            3'd2:    sh = cp >> 12;
            3'd3:    sh = cp >> 18;
            3'd4:    sh = cp >> 24;
            3'd5:    sh = cp >> 30;
            default: sh = '0;
        endcase
        case (n)
            3'd2:    lead = 8'hc0;
            3'd3:    lead = 8'he0;
            3'd4:    lead = 8'hf0;
            3'd5:    lead = 8'hf8;
            3'd6:    lead = 8'hfc;
            default: lead = 8'h00;
        endcase
        if (idx == 3'd0)
            res = lead | sh[7:0];
        else
            res = 8'h80 | {2'b00, sh[5:0]};
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/ucs4_to_utf8_encoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// UCS-4 to UTF-8 encoder (original six-byte form). The input side takes one code point
// per cycle while its four-entry request queue has room; the output side delivers one
// result per cycle from a registered stage while out_stall is low, so a character gives
// one result per byte (1 to 6), and a terminator, truncation or invalid code point gives
// one. Items of a string that has been stopped produce no result but are still taken
// from the input. Capacity resets to 256 and may only be written while the block is idle.
module ucs4_to_utf8_encoder_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [u2u8_pkg::CAP_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [u2u8_pkg::CP_W-1:0]     code_point,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [7:0]                         out_byte,
    output logic                               byte_valid,
    output logic [1:0]                         status,
    output logic [u2u8_pkg::LEN_W-1:0]         length,
    output logic                               last
);
    import u2u8_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_not_empty;
    cmd_t q_wdata;
    cmd_t q_head;

    assign in_stall = q_full;

    u2u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .code_point (code_point),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    u2u8_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_wdata),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    u2u8_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .status      (status),
        .length      (length),
        .last        (last)
    );

endmodule

`default_nettype wire

// ===== design/u2u8_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u2u8_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire u2u8_pkg::cmd_t push_data,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output u2u8_pkg::cmd_t      head
);
    import u2u8_pkg::*;

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== design/u2u8_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u2u8_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [u2u8_pkg::CAP_W-1:0]    cfg_data,
    input  wire logic                          in_valid,
    input  wire logic [u2u8_pkg::CP_W-1:0]     code_point,
    input  wire logic                          q_full,
    output logic                               q_push,
    output u2u8_pkg::cmd_t                     q_data
);
    import u2u8_pkg::*;

    logic [CAP_W-1:0]   capacity_reg;
    logic [COUNT_W-1:0] bw_reg, bw_next;
    logic               stopped_reg, stopped_next;

    logic               accept;
    logic [2:0]         n;
    logic [COUNT_W:0]   sum;
    logic [CMP_W-1:0]   sum_p1_ext;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   bw_ext;

    assign accept     = in_valid && !q_full;
    assign sum        = {1'b0, bw_reg} + (COUNT_W+1)'(n);
    assign sum_p1_ext = CMP_W'(sum) + CMP_W'(1);
    assign cap_ext    = CMP_W'(capacity_reg);
    assign bw_ext     = CMP_W'(bw_reg);

    always_comb
    begin
        if (code_point < 32'h80)
            n = 3'd1;
        else if (code_point < 32'h800)
            n = 3'd2;
        else if (code_point < 32'h10000)
            n = 3'd3;
        else if (code_point < 32'h200000)
            n = 3'd4;
        else if (code_point < 32'h4000000)
            n = 3'd5;
        else
            n = 3'd6;
    end

    always_comb
    begin
        bw_next        = bw_reg;
        stopped_next   = stopped_reg;
        q_push         = 1'b0;
        q_data.kind    = CMD_SINGLE;
        q_data.cp      = code_point[CP_W-2:0];
        q_data.nbytes  = n;
        q_data.bvalid  = 1'b0;
        q_data.status  = ST_END;
        q_data.len     = '0;
        if (accept)
        begin
            if (code_point == '0)
            begin
                bw_next      = '0;
                stopped_next = 1'b0;
                q_push       = !stopped_reg;
                if (bw_ext < cap_ext)
                begin
                    q_data.bvalid = 1'b1;
                    q_data.len    = LEN_W'(bw_reg);
                end
                else if (bw_reg != '0)
                begin
                    q_data.status = ST_TRUNC;
                    q_data.len    = LEN_W'(bw_reg);
                end
            end
            else if (!stopped_reg)
            begin
                q_push = 1'b1;
                if (code_point[CP_W-1])
                begin
                    stopped_next  = 1'b1;
                    q_data.status = ST_INVALID;
                end
                else if (sum_p1_ext > cap_ext || sum[COUNT_W])
                begin
                    // The character plus the NUL does not fit, or the count would wrap.
                    stopped_next  = 1'b1;
                    q_data.status = ST_TRUNC;
                    q_data.len    = LEN_W'(sum);
                end
                else
                begin
                    bw_next       = sum[COUNT_W-1:0];
                    q_data.kind   = CMD_CHAR;
                    q_data.bvalid = 1'b1;
                    q_data.status = ST_CHAR;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            bw_reg       <= '0;
            stopped_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                capacity_reg <= cfg_data;
            bw_reg      <= bw_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/u2u8_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u2u8_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_not_empty,
    input  wire u2u8_pkg::cmd_t                q_head,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [7:0]                         out_byte,
    output logic                               byte_valid,
    output logic [1:0]                         status,
    output logic [u2u8_pkg::LEN_W-1:0]         length,
    output logic                               last
);
    import u2u8_pkg::*;

    logic [2:0]       idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       byte_reg;
    logic             bvalid_reg;
    status_t          status_reg;
    logic [LEN_W-1:0] len_reg;
    logic             last_reg;

    logic             emit;
    logic             is_last;

    assign emit    = q_not_empty && (!out_valid_reg || !out_stall);
    assign is_last = (q_head.kind == CMD_SINGLE) || (idx_reg == q_head.nbytes - 3'd1);
    assign q_pop   = emit && is_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (emit)
            idx_next = is_last ? 3'd0 : idx_reg + 3'd1;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (q_head.kind == CMD_CHAR)
                byte_reg <= utf8_byte(q_head.cp, q_head.nbytes, idx_reg);
            else
                byte_reg <= 8'h00;
            bvalid_reg <= q_head.bvalid;
            status_reg <= q_head.status;
            len_reg    <= q_head.len;
            last_reg   <= is_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = byte_reg;
    assign byte_valid = bvalid_reg;
    assign status     = status_reg;
    assign length     = len_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

// ===== design/u2u8_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module u2u8_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [7:0]                    out_byte,
    input  wire logic                          byte_valid,
    input  wire logic [1:0]                    status,
    input  wire logic [u2u8_pkg::LEN_W-1:0]    length,
    input  wire logic                          last
);
    import u2u8_pkg::*;

    // A stalled result must hold still until it is taken.
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(last) && $stable(status) && $stable(length))
    // Status-only results are always the single, final result of their request.
    `ASSERT_IMPL(a_single_last, out_valid && (status != ST_CHAR), last)
    // A character byte is always a byte to store.
    `ASSERT_IMPL(a_char_valid, out_valid && (status == ST_CHAR), byte_valid && (length == '0))
    // Results with no byte carry a zero byte.
    `ASSERT_IMPL(a_nobyte_zero, out_valid && !byte_valid, out_byte == 8'h00)

endmodule

bind ucs4_to_utf8_encoder_top u2u8_checker u_u2u8_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import u2u8_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 144;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = RANDOM_ITEMS / PHASES;
    localparam int HOLD_PHASE    = 5;
    localparam int HOLD_CYCLES   = 120;
    localparam int SETTLE_CYCLES = 32;
    localparam int IDLE_LIMIT    = 3000;
    localparam int unsigned COUNT_MAX = (32'd1 << COUNT_W) - 1;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        status_t          status;
        logic [LEN_W-1:0] length;
        logic             last;
    } utf8_result_t;

    typedef enum logic [0:0] {
        ROW_CODE_POINT = 1'b0,
        ROW_CAPACITY   = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t       kind;
        logic [CP_W-1:0] value;
        logic            known;
        utf8_result_t    result;
    } directed_row_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic [CAP_W-1:0]     cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic [CP_W-1:0]      code_point = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic [7:0]           out_byte;
    logic                 byte_valid;
    logic [1:0]           status;
    logic [LEN_W-1:0]     length;
    logic                 last;

    // Own copy of the encoder state, kept in step with accepted requests.
    logic [CAP_W-1:0]     capacity_reg    = CAP_RESET;
    logic [COUNT_W-1:0]   bytes_in_string = '0;
    bit                   string_stopped  = 1'b0;
    utf8_result_t         encoded [6];
    utf8_result_t         awaited_results [$];

    int                   mismatches   = 0;
    int                   idle_cycles  = 0;
    bit                   hold_off_req = 1'b0;

    ucs4_to_utf8_encoder_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .code_point (code_point),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .status     (status),
        .length     (length),
        .last       (last)
    );

    always #HALF_PERIOD clk = ~clk;

    // Fills encoded[] with the results of one code point and returns how many there are.
    function automatic int encode_utf8(input logic [CP_W-1:0] cp);
        int unsigned        nbytes;
        int unsigned        grown;
        int                 i;
        logic [7:0]         lead;
        logic [CP_W-1:0]    rest;
        logic [COUNT_W-1:0] count;
        bit                 was_stopped;
        if (cp == '0)
        begin
            was_stopped     = string_stopped;
            count           = bytes_in_string;
            string_stopped  = 1'b0;
            bytes_in_string = '0;
            if (was_stopped)
                return 0;
            if (count < capacity_reg)
                encoded[0] = '{8'h00, 1'b1, ST_END, LEN_W'(count), 1'b1};
            else if (count == '0)
                encoded[0] = '{8'h00, 1'b0, ST_END, LEN_W'(0), 1'b1};
            else
                encoded[0] = '{8'h00, 1'b0, ST_TRUNC, LEN_W'(count), 1'b1};
            return 1;
        end
        if (string_stopped)
            return 0;
        if (cp < 32'h80)
        begin
            nbytes = 1;
            lead   = 8'h00;
        end
        else if (cp < 32'h800)
        begin
            nbytes = 2;
            lead   = 8'hc0;
        end
        else if (cp < 32'h10000)
        begin
            nbytes = 3;
            lead   = 8'he0;
        end
        else if (cp < 32'h200000)
        begin
            nbytes = 4;
            lead   = 8'hf0;
        end
        else if (cp < 32'h4000000)
        begin
            nbytes = 5;
            lead   = 8'hf8;
        end
        else if (cp <= 32'h7fffffff)
        begin
            nbytes = 6;
            lead   = 8'hfc;
        end
        else
        begin
            string_stopped = 1'b1;
            encoded[0] = '{8'h00, 1'b0, ST_INVALID, LEN_W'(0), 1'b1};
            return 1;
        end
        // The terminating NUL must still fit after this character.
        grown = bytes_in_string + nbytes;
        if (grown + 1 > capacity_reg || grown > COUNT_MAX)
        begin
            string_stopped = 1'b1;
            encoded[0] = '{8'h00, 1'b0, ST_TRUNC, LEN_W'(grown), 1'b1};
            return 1;
        end
        rest = cp;
        for (i = int'(nbytes) - 1; i > 0; i--)
        begin
            encoded[i] = '{8'h80 | {2'b00, rest[5:0]}, 1'b1, ST_CHAR, LEN_W'(0),
                           i == int'(nbytes) - 1};
            rest = rest >> 6;
        end
        encoded[0] = '{lead | rest[7:0], 1'b1, ST_CHAR, LEN_W'(0), nbytes == 1};
        bytes_in_string = grown[COUNT_W-1:0];
        return int'(nbytes);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [CP_W-1:0] random_code_point();
        case ($urandom_range(0, 15))
            0, 1, 2, 15: return $urandom_range(1, 32'h7f);
            3, 4:        return $urandom_range(32'h80, 32'h7ff);
            5, 6:        return $urandom_range(32'h800, 32'hffff);
            7, 8:        return $urandom_range(32'h10000, 32'h1fffff);
            9, 10:       return $urandom_range(32'h200000, 32'h3ffffff);
            11, 12:      return $urandom_range(32'h4000000, 32'h7fffffff);
            13:          return 32'h8000_0000 | $urandom;
            default:     return $urandom;
        endcase
    endfunction

    function automatic directed_row_t code_row(input logic [CP_W-1:0] cp);
        directed_row_t row;
        row = '{ROW_CODE_POINT, cp, 1'b0, '0};
        return row;
    endfunction

    function automatic directed_row_t known_row(input logic [CP_W-1:0] cp,
                                                input logic [7:0] b, input logic bv,
                                                input status_t st,
                                                input logic [LEN_W-1:0] len);
        directed_row_t row;
        row = '{ROW_CODE_POINT, cp, 1'b1, '{b, bv, st, len, 1'b1}};
        return row;
    endfunction

    function automatic directed_row_t capacity_row(input logic [CAP_W-1:0] cap);
        directed_row_t row;
        row = '{ROW_CAPACITY, CP_W'(cap), 1'b0, '0};
        return row;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic offer_code_point(input logic [CP_W-1:0] cp, input bit typed,
                                    input utf8_result_t typed_result, input bit steady);
        int gap;
        int k;
        int produced;
        in_valid   <= 1'b1;
        code_point <= cp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        produced = encode_utf8(cp);
        if (typed)
            awaited_results.push_back(typed_result);
        else
            for (k = 0; k < produced; k++)
                awaited_results.push_back(encoded[k]);
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stopped strings leave no result behind, so allow the pipeline to empty as well.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        capacity_reg = value;
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        directed_row_t    rows [$];
        logic [CAP_W-1:0] phase_caps [PHASES];
        utf8_result_t     none;
        int               phase_count;
        int               chars;
        int               p;
        bit               steady;
        none = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back(known_row(32'h0, 8'h00, 1'b1, ST_END, LEN_W'(0)));
        rows.push_back(known_row(32'h41, 8'h41, 1'b1, ST_CHAR, LEN_W'(0)));
        rows.push_back(known_row(32'h7f, 8'h7f, 1'b1, ST_CHAR, LEN_W'(0)));
        rows.push_back(code_row(32'h80));
        rows.push_back(code_row(32'h7ff));
        rows.push_back(code_row(32'h800));
        rows.push_back(code_row(32'hffff));
        rows.push_back(code_row(32'h10000));
        rows.push_back(code_row(32'h1fffff));
        rows.push_back(code_row(32'h200000));
        rows.push_back(code_row(32'h3ffffff));
        rows.push_back(code_row(32'h4000000));
        rows.push_back(code_row(32'h7fffffff));
        rows.push_back(code_row(32'h0));
        // An invalid code point stops the string until its terminator.
        rows.push_back(known_row(32'h8000_0000, 8'h00, 1'b0, ST_INVALID, LEN_W'(0)));
        rows.push_back(code_row(32'h41));
        rows.push_back(code_row(32'h0));
        // With no buffer at all nothing may be stored.
        rows.push_back(capacity_row(16'd0));
        rows.push_back(known_row(32'h0, 8'h00, 1'b0, ST_END, LEN_W'(0)));
        rows.push_back(known_row(32'h41, 8'h00, 1'b0, ST_TRUNC, LEN_W'(1)));
        rows.push_back(code_row(32'h0));
        rows.push_back(capacity_row(16'd3));
        rows.push_back(code_row(32'h41));
        rows.push_back(code_row(32'h41));
        rows.push_back(known_row(32'h41, 8'h00, 1'b0, ST_TRUNC, LEN_W'(3)));
        rows.push_back(code_row(32'h0));
        // The buffer shrinks under an open string, so the NUL no longer fits.
        rows.push_back(capacity_row(16'hffff));
        rows.push_back(code_row(32'h263a));
        rows.push_back(code_row(32'h41));
        rows.push_back(capacity_row(16'd2));
        rows.push_back(known_row(32'h0, 8'h00, 1'b0, ST_TRUNC, LEN_W'(4)));

        foreach (rows[r])
        begin
            if (rows[r].kind == ROW_CAPACITY)
                write_capacity(rows[r].value[CAP_W-1:0]);
            else
                offer_code_point(rows[r].value, rows[r].known, rows[r].result, 1'b0);
        end

        phase_caps = '{16'd1, 16'd2, 16'd7, 16'd16, 16'd64, 16'd256, 16'hffff,
                       CAP_W'($urandom_range(0, 65535))};
        for (p = 0; p < PHASES; p++)
        begin
            write_capacity(phase_caps[p]);
            steady = (p == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
            if (p == HOLD_PHASE)
                hold_off_req = 1'b1;
            phase_count = 0;
            while (phase_count < PHASE_ITEMS)
            begin
                // Leave room in the phase for the terminator of this string.
                chars = $urandom_range(0, 8);
                if (chars > PHASE_ITEMS - phase_count - 1)
                    chars = PHASE_ITEMS - phase_count - 1;
                repeat (chars)
                begin
                    offer_code_point(random_code_point(), 1'b0, none, steady);
                    phase_count++;
                end
                offer_code_point('0, 1'b0, none, steady);
                phase_count++;
            end
        end

        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin : receiver
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_CYCLES;
                run_left     = 0;
            end
            else if (stall_left == 0 && run_left == 0)
            begin
                stall_left = pick_gap();
                run_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 4);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                run_left--;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        utf8_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with no request pending: out_byte %h status %0d length %0d",
                       out_byte, status, length);
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("out_byte", 32'(want.out_byte), 32'(out_byte));
                check_field("byte_valid", 32'(want.byte_valid), 32'(byte_valid));
                check_field("status", 32'(want.status), 32'(status));
                check_field("length", 32'(want.length), 32'(length));
                check_field("last", 32'(want.last), 32'(last));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule

// ===== ucs4_to_utf8_encoder_top.f =====
+incdir+design
design/u2u8_pkg.sv
design/u2u8_queue.sv
design/u2u8_front.sv
design/u2u8_back.sv
design/ucs4_to_utf8_encoder_top.sv
design/u2u8_checker.sv
tb/tb_top.sv
